[rtl/scaled_fixed_point_to_decimal_text_top_defines.svh]
// Assertion macros used by the checker file.
`ifndef SCALED_FIXED_POINT_TO_DECIMAL_TEXT_TOP_DEFINES_SVH
`define SCALED_FIXED_POINT_TO_DECIMAL_TEXT_TOP_DEFINES_SVH

// Checked only while the block is out of reset.
`define SFDT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SFDT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/sfdt_pkg.sv]
package sfdt_pkg;

    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 8;
    localparam int IP_W    = 15;
    localparam int FRAC_W  = 16;
    localparam int POS_W   = 3;
    localparam int STEP_W  = 3;
    localparam int S_W     = 20;

    localparam logic [POS_W-1:0]  INT_POS_LAST   = 3'd4;
    localparam logic [STEP_W-1:0] FRAC_STEP_LAST = 3'd5;

    // The published rounding adds 32768 and takes away 50000 in one go.
    localparam logic [S_W:0] ROUND_SUB = 21'd17232;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic              neg;
        logic [IP_W-1:0]   ip;
        logic [FRAC_W-1:0] frac;
        logic [POS_W-1:0]  start_pos;
    } job_t;

    // Place value of an integer digit position, most significant first.
    function automatic logic [13:0] pow10_int(input logic [POS_W-1:0] pos);
        logic [13:0] p;
        unique case (pos)
            3'd0:    p = 14'd10000;
            3'd1:    p = 14'd1000;
            3'd2:    p = 14'd100;
            3'd3:    p = 14'd10;
            default: p = 14'd1;
        endcase
        return p;
    endfunction

    // Precision that the remainder must exceed after a fraction digit.
    function automatic logic [16:0] frac_limit(input logic [STEP_W-1:0] step);
        logic [16:0] l;
        unique case (step)
            3'd1:    l = 17'd100;
            3'd2:    l = 17'd1000;
            3'd3:    l = 17'd10000;
            default: l = 17'd100000;
        endcase
        return l;
    endfunction

endpackage

[rtl/sfdt_if.sv]
interface sfdt_num_if;
    logic                                valid;
    logic                                ready;
    logic signed [sfdt_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sfdt_text_if;
    logic                         valid;
    logic                         ready;
    logic [sfdt_pkg::CHAR_W-1:0]  character;
    logic                         last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

[rtl/sfdt_front.sv]
module sfdt_front (
    sfdt_num_if.sink         number,
    input  logic             queue_full,
    output logic             push,
    output sfdt_pkg::job_t   push_job
);

    logic [sfdt_pkg::VALUE_W-1:0] raw;
    logic [sfdt_pkg::VALUE_W-1:0] mag;
    logic                         neg;

    assign raw = number.value;
    assign neg = raw[sfdt_pkg::VALUE_W-1];

    // The most negative value has no positive twin and is pulled in by one.
    always_comb
    begin
        if (raw == {1'b1, {(sfdt_pkg::VALUE_W-1){1'b0}}})
        begin
            mag = {1'b0, {(sfdt_pkg::VALUE_W-1){1'b1}}};
        end
        else if (neg)
        begin
            mag = (~raw) + 32'd1;
        end
        else
        begin
            mag = raw;
        end
    end

    assign number.ready = !queue_full;
    assign push         = number.valid && !queue_full;

    always_comb
    begin
        push_job.neg  = neg;
        push_job.ip   = mag[30:16];
        push_job.frac = mag[15:0];
        priority if (mag[30:16] >= 15'd10000)
        begin
            push_job.start_pos = 3'd0;
        end
        else if (mag[30:16] >= 15'd1000)
        begin
            push_job.start_pos = 3'd1;
        end
        else if (mag[30:16] >= 15'd100)
        begin
            push_job.start_pos = 3'd2;
        end
        else if (mag[30:16] >= 15'd10)
        begin
            push_job.start_pos = 3'd3;
        end
        else
        begin
            push_job.start_pos = sfdt_pkg::INT_POS_LAST;
        end
    end

endmodule

[rtl/sfdt_queue.sv]
module sfdt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sfdt_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           pop_valid,
    output sfdt_pkg::job_t pop_job
);

    sfdt_pkg::job_t                    entry_reg [sfdt_pkg::QUEUE_DEPTH];
    logic [sfdt_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [sfdt_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [sfdt_pkg::QCNT_W-1:0]       count_reg;
    logic [sfdt_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [sfdt_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [sfdt_pkg::QCNT_W-1:0]       count_next;
    logic                              do_push;
    logic                              do_pop;

    assign full      = (count_reg == sfdt_pkg::QCNT_W'(sfdt_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_job   = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == sfdt_pkg::QPTR_W'(sfdt_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == sfdt_pkg::QPTR_W'(sfdt_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[rtl/sfdt_back.sv]
module sfdt_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    input  sfdt_pkg::job_t   job,
    output logic             pop,
    sfdt_text_if.source      text
);

    typedef enum logic [1:0] {ST_IDLE, ST_INT, ST_POINT, ST_FRAC} state_t;

    state_t                          state_reg, state_next;
    logic [sfdt_pkg::IP_W-1:0]       ip_reg, ip_next;
    logic [sfdt_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [sfdt_pkg::FRAC_W-1:0]     frac_reg, frac_next;
    logic [sfdt_pkg::S_W-1:0]        s_reg, s_next;
    logic [sfdt_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [sfdt_pkg::CHAR_W-1:0]     char_reg, char_next;
    logic                            last_reg, last_next;
    logic                            ovalid_reg, ovalid_next;

    logic                            adv;
    logic [sfdt_pkg::IP_W-1:0]       src_ip;
    logic [sfdt_pkg::POS_W-1:0]      src_pos;
    logic [13:0]                     place;
    logic [3:0]                      int_digit;
    logic [17:0]                     int_prod;
    logic [sfdt_pkg::IP_W-1:0]       int_rem;
    logic [sfdt_pkg::S_W:0]          s_adj;
    logic [3:0]                      frac_digit;
    logic [sfdt_pkg::S_W-1:0]        s_new;
    logic                            frac_last;

    assign adv     = !ovalid_reg || text.ready;
    assign src_ip  = (state_reg == ST_IDLE) ? job.ip : ip_reg;
    assign src_pos = (state_reg == ST_IDLE) ? job.start_pos : pos_reg;
    assign place   = sfdt_pkg::pow10_int(src_pos);

    // The remaining integer part is always below ten times the place value,
    // so the digit is the number of multiples that still fit.
    always_comb
    begin
        int_digit = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if ({2'b00, src_ip} >= 17'(k) * {3'b000, place})
            begin
                int_digit = 4'(k);
            end
        end
    end

    assign int_prod = {14'd0, int_digit} * {4'd0, place};
    assign int_rem  = src_ip - int_prod[sfdt_pkg::IP_W-1:0];

    // Only the fifth fraction digit is rounded; it is also always the last.
    assign s_adj = {1'b0, s_reg}
                   - ((step_reg == sfdt_pkg::FRAC_STEP_LAST) ? sfdt_pkg::ROUND_SUB : '0);
    assign frac_digit = s_adj[sfdt_pkg::S_W] ? 4'd0 : s_adj[19:16];
    assign s_new = {1'b0, s_adj[15:0], 3'b000} + {3'b000, s_adj[15:0], 1'b0};
    assign frac_last = (step_reg == sfdt_pkg::FRAC_STEP_LAST)
                       || !(s_new > {3'b000, sfdt_pkg::frac_limit(step_reg)});

    assign text.valid     = ovalid_reg;
    assign text.character = char_reg;
    assign text.last_char = last_reg;

    always_comb
    begin
        state_next  = state_reg;
        ip_next     = ip_reg;
        pos_next    = pos_reg;
        frac_next   = frac_reg;
        s_next      = s_reg;
        step_next   = step_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        ovalid_next = ovalid_reg && !text.ready;
        pop         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (adv && job_valid)
                begin
                    pop         = 1'b1;
                    ovalid_next = 1'b1;
                    last_next   = 1'b0;
                    frac_next   = job.frac;
                    ip_next     = job.ip;
                    pos_next    = job.start_pos;
                    if (job.neg)
                    begin
                        char_next  = sfdt_pkg::CHAR_MINUS;
                        state_next = ST_INT;
                    end
                    else
                    begin
                        char_next = sfdt_pkg::CHAR_ZERO + {4'd0, int_digit};
                        ip_next   = int_rem;
                        if (src_pos == sfdt_pkg::INT_POS_LAST)
                        begin
                            state_next = ST_POINT;
                        end
                        else
                        begin
                            pos_next   = src_pos + 1'b1;
                            state_next = ST_INT;
                        end
                    end
                end
            end
            ST_INT:
            begin
                if (adv)
                begin
                    ovalid_next = 1'b1;
                    last_next   = 1'b0;
                    char_next   = sfdt_pkg::CHAR_ZERO + {4'd0, int_digit};
                    ip_next     = int_rem;
                    if (src_pos == sfdt_pkg::INT_POS_LAST)
                    begin
                        state_next = ST_POINT;
                    end
                    else
                    begin
                        pos_next = src_pos + 1'b1;
                    end
                end
            end
            ST_POINT:
            begin
                if (adv)
                begin
                    ovalid_next = 1'b1;
                    last_next   = 1'b0;
                    char_next   = sfdt_pkg::CHAR_POINT;
                    s_next      = {1'b0, frac_reg, 3'b000} + {3'b000, frac_reg, 1'b0} + 20'd5;
                    step_next   = 3'd1;
                    state_next  = ST_FRAC;
                end
            end
            ST_FRAC:
            begin
                if (adv)
                begin
                    ovalid_next = 1'b1;
                    last_next   = frac_last;
                    char_next   = sfdt_pkg::CHAR_ZERO + {4'd0, frac_digit};
                    if (frac_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        s_next    = s_new;
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            ip_reg     <= '0;
            pos_reg    <= '0;
            frac_reg   <= '0;
            s_reg      <= '0;
            step_reg   <= '0;
            char_reg   <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            ip_reg     <= ip_next;
            pos_reg    <= pos_next;
            frac_reg   <= frac_next;
            s_reg      <= s_next;
            step_reg   <= step_next;
            char_reg   <= char_next;
            last_reg   <= last_next;
        end
    end

endmodule

[rtl/scaled_fixed_point_to_decimal_text_top.sv]
// Converts each signed 16.16 fixed-point item on number into its decimal text
// on text, one ASCII character per output item: an optional '-', the integer
// digits without leading zeros, '.', then the shortest run of fraction digits
// that reads back to the same value, with last_char set on the final one. A
// value yields 3 to 12 characters; the emit sequencer sends one character per
// cycle while text is ready, and the input side classifies a value in the
// cycle it is accepted and parks it in a two-entry queue, so number stays
// ready while the queue has room.
module scaled_fixed_point_to_decimal_text_top (
    input  logic        clk,
    input  logic        rst_n,
    sfdt_num_if.sink    number,
    sfdt_text_if.source text
);

    sfdt_pkg::job_t push_job;
    sfdt_pkg::job_t pop_job;
    logic           push;
    logic           queue_full;
    logic           pop;
    logic           pop_valid;

    sfdt_front u_front (
        .number     (number),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    sfdt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_job   (pop_job)
    );

    sfdt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job       (pop_job),
        .pop       (pop),
        .text      (text)
    );

endmodule

[rtl/sfdt_checker.sv]
`include "scaled_fixed_point_to_decimal_text_top_defines.svh"

module sfdt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [sfdt_pkg::CHAR_W-1:0] character,
    input logic                        last_char
);

    logic is_digit;

    assign is_digit = (character >= sfdt_pkg::CHAR_ZERO) && (character <= sfdt_pkg::CHAR_NINE);

    // A stalled character must not change or vanish.
    `SFDT_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last_char), "text item changed while stalled")

    `SFDT_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "text valid during reset")

    `SFDT_ASSERT(a_legal_char, out_valid |-> is_digit || character == sfdt_pkg::CHAR_MINUS || character == sfdt_pkg::CHAR_POINT, "illegal character")

    // The text always ends on a fraction digit.
    `SFDT_ASSERT(a_last_digit, out_valid && last_char |-> is_digit, "text ends on a sign or point")

endmodule

bind scaled_fixed_point_to_decimal_text_top sfdt_checker u_sfdt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (text.valid),
    .out_ready (text.ready),
    .character (text.character),
    .last_char (text.last_char)
);
